>>> sv/cws_pkg.sv
`timescale 1ns / 1ps
package cws_pkg;

  localparam int MAX_WINDOW   = 63;
  localparam int TIMING_SLOTS = 1024;
  localparam int SLOT_W       = $clog2(TIMING_SLOTS);
  localparam int MAX_GRANTS   = 63;
  localparam int GRANT_CNT_W  = $clog2(MAX_GRANTS + 1);

  localparam logic [22:0] ONE_Q16  = 23'h010000;
  localparam longint      CAP_FULL = longint'(MAX_WINDOW) * 65536;
  localparam logic [22:0] WINDOW_CAP = (CAP_FULL > 64'h7FFFFF) ? 23'h7FFFFF : 23'(CAP_FULL);

  localparam int DIV_STEPS = 33;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [19:0] FINAL_SEQ_RST  = 20'd0;
  localparam logic [15:0] TMO_OFFSET_RST = 16'd50;
  localparam logic [15:0] INIT_RTT_RST   = 16'd3000;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_FINAL_SEQ  = 2'd0,
    REG_TMO_OFFSET = 2'd1,
    REG_INIT_RTT   = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [19:0] final_sequence;
    logic [15:0] timeout_offset_ms;
    logic [15:0] initial_round_trip_ms;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic measure;
    logic apply;
    logic div_step;
    logic div_add;
    logic run;
  } cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
    logic grant_ok;
  } sts_t;

endpackage

>>> sv/cws_regs.sv
`timescale 1ns / 1ps
module cws_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output cws_pkg::cfg_t  cfg
);
  import cws_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.final_sequence        <= FINAL_SEQ_RST;
      cfg_r.timeout_offset_ms     <= TMO_OFFSET_RST;
      cfg_r.initial_round_trip_ms <= INIT_RTT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_FINAL_SEQ:  cfg_r.final_sequence        <= pwdata[19:0];
        REG_TMO_OFFSET: cfg_r.timeout_offset_ms     <= pwdata[15:0];
        REG_INIT_RTT:   cfg_r.initial_round_trip_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FINAL_SEQ:  prdata = {12'd0, cfg_r.final_sequence};
      REG_TMO_OFFSET: prdata = {16'd0, cfg_r.timeout_offset_ms};
      REG_INIT_RTT:   prdata = {16'd0, cfg_r.initial_round_trip_ms};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

>>> sv/cws_ctrl.sv
`timescale 1ns / 1ps
module cws_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    in_operation,
  input  cws_pkg::sts_t sts,
  output cws_pkg::cmd_t cmd,
  output logic          busy
);
  import cws_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOKUP, ST_MEASURE, ST_DIVIDE, ST_ADD, ST_APPLY, ST_GRANT
  } state_t;

  state_t st_r;
  logic   busy_r;
  op_t    op;

  assign op   = op_t'(in_operation);
  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      busy_r <= 1'b0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (start) begin
            unique case (op)
              OP_ACK:     begin st_r <= ST_LOOKUP; busy_r <= 1'b1; end
              OP_START,
              OP_TIMEOUT: begin st_r <= ST_APPLY;  busy_r <= 1'b1; end
              default: ;
            endcase
          end
        end
        ST_LOOKUP:  st_r <= ST_MEASURE;
        ST_MEASURE: st_r <= sts.div_needed ? ST_DIVIDE : ST_GRANT;
        ST_DIVIDE: begin
          if (sts.div_last) st_r <= ST_ADD;
        end
        ST_ADD:   st_r <= ST_GRANT;
        ST_APPLY: st_r <= ST_GRANT;
        ST_GRANT: begin
          if (!sts.grant_ok) begin
            st_r   <= ST_IDLE;
            busy_r <= 1'b0;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (st_r == ST_IDLE) && start;
    cmd.measure  = (st_r == ST_MEASURE);
    cmd.apply    = (st_r == ST_APPLY);
    cmd.div_step = (st_r == ST_DIVIDE);
    cmd.div_add  = (st_r == ST_ADD);
    cmd.run      = (st_r == ST_GRANT);
  end

  ap_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (st_r != ST_IDLE)) else $error("busy out of step with state");
  ap_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIVIDE && sts.div_last |=> st_r == ST_ADD) else $error("divider exit");
  ap_none_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_IDLE && start && op == OP_NONE |=> st_r == ST_IDLE)
    else $error("unused operation not ignored");

endmodule

>>> sv/cws_datapath.sv
`timescale 1ns / 1ps
module cws_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  cws_pkg::cfg_t cfg,
  input  cws_pkg::cmd_t cmd,
  output cws_pkg::sts_t sts,
  input  logic [1:0]    in_operation,
  input  logic [20:0]   in_ack_sequence,
  input  logic [31:0]   in_now_ms,
  output logic          out_strobe,
  output logic          out_result_kind,
  output logic [19:0]   out_send_sequence,
  output logic [16:0]   out_timeout_ms,
  output logic [6:0]    out_window_whole,
  output logic          out_avoidance_mode,
  output logic          out_transfer_done,
  output logic          out_last_of_run
);
  import cws_pkg::*;

  op_t         op_r;
  logic [20:0] ack_r;
  logic [31:0] now_r;

  logic [20:0] ha_r;
  logic [22:0] wf_r;
  logic        mode_r;
  logic [6:0]  inflt_r;
  logic [15:0] rtt_r;
  logic [GRANT_CNT_W-1:0] gcnt_r;

  logic [51:0] slot_mem [TIMING_SLOTS];
  logic [51:0] rd_r;

  logic [23:0] rem_r;
  logic [32:0] den_r;
  logic [16:0] q_r;
  logic [DIV_CNT_W-1:0] dcnt_r;

  logic        strobe_r, kind_r, mode_o_r, done_r, last_r;
  logic [19:0] seq_o_r;
  logic [16:0] tmo_r;
  logic [6:0]  whole_r;

  logic signed [21:0] ack_s, ha_s, adv, base_s, fin_s, seq_s;
  logic        advance, dup, hit;
  logic [31:0] rtt_diff;
  logic [23:0] trial, ss_sum, av_sum;
  logic [22:0] half;
  logic [21:0] inflt_ext;

  assign ack_s     = {ack_r[20], ack_r};
  assign ha_s      = {ha_r[20], ha_r};
  assign fin_s     = {2'b00, cfg.final_sequence};
  assign inflt_ext = {15'd0, inflt_r};
  assign advance   = ack_s > ha_s;
  assign dup       = ack_s == ha_s;
  assign adv       = ack_s - ha_s;
  assign hit       = !ack_r[20] && (rd_r[51:32] == ack_r[19:0]);
  assign rtt_diff  = now_r - rd_r[31:0];
  assign base_s    = ha_s + $signed(inflt_ext);
  assign seq_s     = base_s + 22'sd1;
  assign trial     = {rem_r[22:0], den_r[32]};
  assign ss_sum    = {1'b0, wf_r} + {1'b0, ONE_Q16};
  assign av_sum    = {1'b0, wf_r} + {7'd0, q_r};
  assign half      = {1'b0, wf_r[22:1]};

  assign sts.div_needed = advance && mode_r && (wf_r != 23'd0);
  assign sts.div_last   = dcnt_r == DIV_CNT_W'(DIV_STEPS - 1);
  assign sts.grant_ok   = (gcnt_r != GRANT_CNT_W'(MAX_GRANTS)) && (inflt_r < wf_r[22:16])
                          && (inflt_r != 7'd127) && (base_s < fin_s);

  always_ff @(posedge clk) begin
    rd_r <= slot_mem[ack_r[SLOT_W-1:0]];
    if (cmd.run && sts.grant_ok)
      slot_mem[seq_s[SLOT_W-1:0]] <= {seq_s[19:0], now_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_operation);
      ack_r <= in_ack_sequence;
      now_r <= in_now_ms;
    end
    if (cmd.measure) begin
      rem_r  <= '0;
      den_r  <= {1'b1, 32'd0};
      q_r    <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, wf_r}) begin
        rem_r <= trial - {1'b0, wf_r};
        q_r   <= {q_r[15:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[15:0], 1'b0};
      end
      den_r  <= {den_r[31:0], 1'b0};
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ha_r     <= '1;
      wf_r     <= ONE_Q16;
      mode_r   <= 1'b0;
      inflt_r  <= '0;
      rtt_r    <= INIT_RTT_RST;
      gcnt_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.run;
      if (cmd.load) gcnt_r <= '0;
      if (cmd.apply || (cmd.measure && !advance && dup)) begin
        if (cmd.apply && op_r == OP_START) begin
          ha_r    <= '1;
          wf_r    <= ONE_Q16;
          mode_r  <= 1'b0;
          inflt_r <= '0;
          rtt_r   <= cfg.initial_round_trip_ms;
        end else begin
          inflt_r <= '0;
          if (half[22:16] == 7'd0) begin
            wf_r   <= ONE_Q16;
            mode_r <= 1'b0;
          end else begin
            wf_r   <= half;
            mode_r <= 1'b1;
          end
        end
      end
      if (cmd.measure) begin
        if (hit) rtt_r <= (rtt_diff > 32'hFFFF) ? 16'hFFFF : rtt_diff[15:0];
        if (advance) begin
          ha_r    <= ack_r;
          inflt_r <= (adv > $signed(inflt_ext)) ? 7'd0 : inflt_r - adv[6:0];
          if (!mode_r) wf_r <= (ss_sum > {1'b0, WINDOW_CAP}) ? WINDOW_CAP : ss_sum[22:0];
        end
      end
      if (cmd.div_add)
        wf_r <= (av_sum > {1'b0, WINDOW_CAP}) ? WINDOW_CAP : av_sum[22:0];
      if (cmd.run && sts.grant_ok) begin
        inflt_r <= inflt_r + 1'b1;
        gcnt_r  <= gcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run) begin
      kind_r   <= !sts.grant_ok;
      last_r   <= !sts.grant_ok;
      seq_o_r  <= sts.grant_ok ? seq_s[19:0] : 20'd0;
      tmo_r    <= {1'b0, rtt_r} + {1'b0, cfg.timeout_offset_ms};
      whole_r  <= wf_r[22:16];
      mode_o_r <= mode_r;
      done_r   <= ha_s >= fin_s;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_result_kind    = kind_r;
  assign out_send_sequence  = seq_o_r;
  assign out_timeout_ms     = tmo_r;
  assign out_window_whole   = whole_r;
  assign out_avoidance_mode = mode_o_r;
  assign out_transfer_done  = done_r;
  assign out_last_of_run    = last_r;

  ap_win_floor: assert property (@(posedge clk) disable iff (!rst_n)
    wf_r[22:16] != 7'd0) else $error("window integer part zero");
  ap_win_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wf_r <= WINDOW_CAP) else $error("window above cap");
  ap_grant_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run && sts.grant_ok |=> inflt_r <= wf_r[22:16]) else $error("in flight beyond window");

endmodule

>>> sv/congestion_window_sender_core.sv
`timescale 1ns / 1ps
// channel   handshake                         payload
// in        start & !busy                     in_operation, in_ack_sequence, in_now_ms
// out       out_strobe, one cycle             out_result_kind .. out_last_of_run
// cfg       psel & penable & pwrite           paddr, pwdata, prdata, pready
// start or timeout: load, apply, then the grant state issues each grant and the status
// ack: load, lookup, measure, then grants and status; an advancing ack in avoidance
//   first runs the serial reciprocal divider and the window add
// send-time table is a simple dual-port memory, read during the ack lookup cycle
// rst_n is synchronous; the table keeps its contents across reset
// results go out one per cycle and the receiver cannot stall them
module congestion_window_sender_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [20:0] in_ack_sequence,
  input  logic [31:0] in_now_ms,
  output logic        out_strobe,
  output logic        out_result_kind,
  output logic [19:0] out_send_sequence,
  output logic [16:0] out_timeout_ms,
  output logic [6:0]  out_window_whole,
  output logic        out_avoidance_mode,
  output logic        out_transfer_done,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cws_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  cws_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  cws_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_operation(in_operation),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  cws_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_ack_sequence(in_ack_sequence), .in_now_ms(in_now_ms),
    .out_strobe(out_strobe), .out_result_kind(out_result_kind),
    .out_send_sequence(out_send_sequence), .out_timeout_ms(out_timeout_ms),
    .out_window_whole(out_window_whole), .out_avoidance_mode(out_avoidance_mode),
    .out_transfer_done(out_transfer_done), .out_last_of_run(out_last_of_run)
  );

  ap_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_of_run |-> !busy) else $error("busy after status");
  ap_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_result_kind == out_last_of_run) else $error("kind and last differ");
  ap_grant_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_of_run |-> !out_transfer_done) else $error("grant after done");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import cws_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [19:0] seq;
    logic [16:0] tmo;
    logic [6:0]  whole;
    logic        mode;
    logic        done;
    logic        last;
  } window_result_t;

  class window_scoreboard;
    logic [19:0] final_seq;
    logic [15:0] tmo_offset;
    logic [15:0] init_rtt;
    int          acked;
    logic [22:0] window;
    logic        mode;
    int          flight;
    logic [15:0] rtt;
    logic [19:0] slot_seq [TIMING_SLOTS];
    logic [31:0] slot_time [TIMING_SLOTS];
    bit          slot_used [TIMING_SLOTS];
    window_result_t pending[$];
    int errors, results, grants, items;

    function new();
      final_seq = FINAL_SEQ_RST;
      tmo_offset = TMO_OFFSET_RST;
      init_rtt = INIT_RTT_RST;
      restart();
    endfunction

    function void restart();
      acked = -1;
      window = ONE_Q16;
      mode = 1'b0;
      flight = 0;
      rtt = init_rtt;
    endfunction

    function void loss();
      window = window >> 1;
      mode = 1'b1;
      flight = 0;
      if (window[22:16] == 0) begin
        window = ONE_Q16;
        mode = 1'b0;
      end
    endfunction

    function bit safe_ack(int a);
      return a < 0 || slot_used[a % TIMING_SLOTS];
    endfunction

    // predicts the grants and the status of one accepted transaction
    function void note_event(op_t op, logic [20:0] raw, logic [31:0] now);
      int a;
      int slot;
      int n;
      longint unsigned d;
      window_result_t r;
      a = int'($signed(raw));
      items++;
      if (op == OP_NONE) return;
      if (op == OP_START) restart();
      else if (op == OP_TIMEOUT) loss();
      else begin
        if (a >= 0) begin
          slot = a % TIMING_SLOTS;
          if (slot_seq[slot] == 20'(a)) begin
            d = longint'(32'(now - slot_time[slot]));
            rtt = (d > 65535) ? 16'hFFFF : 16'(d);
          end
        end
        if (a > acked) begin
          flight = flight - (a - acked);
          if (flight < 0) flight = 0;
          acked = a;
          if (!mode) window = window + ONE_Q16;
          else if (window != 0) window = window + 23'((64'd1 << 32) / window);
          if (window > WINDOW_CAP) window = WINDOW_CAP;
        end else if (a == acked) loss();
      end
      n = 0;
      r.tmo = 17'(rtt) + 17'(tmo_offset);
      r.whole = window[22:16];
      r.mode = mode;
      r.done = longint'(acked) >= longint'(final_seq);
      while (n < MAX_GRANTS && flight < int'(window[22:16]) && flight < 127 &&
             longint'(acked) + flight < longint'(final_seq)) begin
        r.seq = 20'(acked + flight + 1);
        slot = (acked + flight + 1) % TIMING_SLOTS;
        slot_seq[slot] = r.seq;
        slot_time[slot] = now;
        slot_used[slot] = 1'b1;
        flight++;
        r.kind = 1'b0;
        r.last = 1'b0;
        pending.push_back(r);
        n++;
      end
      grants += n;
      r.kind = 1'b1;
      r.seq = '0;
      r.last = 1'b1;
      pending.push_back(r);
    endfunction

    function void check_result(window_result_t got);
      window_result_t exp;
      results++;
      if (pending.size() == 0) begin
        $error("result with no transaction pending");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind) begin
        $error("result_kind exp %0d got %0d", exp.kind, got.kind); errors++;
      end
      if (got.seq !== exp.seq) begin
        $error("send_sequence exp %0d got %0d", exp.seq, got.seq); errors++;
      end
      if (got.tmo !== exp.tmo) begin
        $error("timeout_ms exp %0d got %0d", exp.tmo, got.tmo); errors++;
      end
      if (got.whole !== exp.whole) begin
        $error("window_whole exp %0d got %0d", exp.whole, got.whole); errors++;
      end
      if (got.mode !== exp.mode) begin
        $error("avoidance_mode exp %0d got %0d", exp.mode, got.mode); errors++;
      end
      if (got.done !== exp.done) begin
        $error("transfer_done exp %0d got %0d", exp.done, got.done); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last_of_run exp %0d got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 2000000;

  logic clk, rst_n, start, busy;
  logic [1:0]  in_operation;
  logic [20:0] in_ack_sequence;
  logic [31:0] in_now_ms;
  logic        out_strobe, out_result_kind, out_avoidance_mode;
  logic        out_transfer_done, out_last_of_run;
  logic [19:0] out_send_sequence;
  logic [16:0] out_timeout_ms;
  logic [6:0]  out_window_whole;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  window_scoreboard sb;
  int          cycles;
  bit          idling;
  logic [31:0] clock_ms;

  congestion_window_sender_core u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result({out_result_kind, out_send_sequence, out_timeout_ms,
                       out_window_whole, out_avoidance_mode, out_transfer_done,
                       out_last_of_run});
  end

  task automatic send_event(op_t op, logic [20:0] ack, logic [31:0] now);
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_ack_sequence <= ack;
    in_now_ms <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_event(op, ack, now);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FINAL_SEQ:  sb.final_seq = value[19:0];
      REG_TMO_OFFSET: sb.tmo_offset = value[15:0];
      REG_INIT_RTT:   sb.init_rtt = value[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] next_now();
    if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 300);
    return clock_ms;
  endfunction

  // picks an ack value that is negative or whose timing slot has been written
  function automatic logic [20:0] pick_ack();
    int a;
    int k;
    k = $urandom_range(0, 99);
    if (k < 70 && sb.flight > 0) a = sb.acked + $urandom_range(1, sb.flight);
    else if (k < 80) a = sb.acked;
    else if (k < 88 && sb.acked > 0) a = sb.acked - $urandom_range(1, sb.acked < 20 ? sb.acked : 20);
    else if (k < 94) a = int'(sb.final_seq) + $urandom_range(0, 3);
    else a = -int'($urandom_range(1, 1048576));
    if (a > 999998 || !sb.safe_ack(a)) a = -1;
    return 21'(a);
  endfunction

  task automatic random_phase(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 82) send_event(OP_ACK, pick_ack(), next_now());
      else if (k < 90) send_event(OP_TIMEOUT, 21'($urandom), next_now());
      else if (k < 96) send_event(OP_START, 21'($urandom), next_now());
      else send_event(OP_NONE, 21'($urandom), next_now());
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_START;
    in_ack_sequence = '0;
    in_now_ms = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    idling = 1'b1;
    clock_ms = 32'd1000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, first grant, dup, timeout, collapse, op three
    send_event(OP_START, 21'h1FFFFF, 32'd0);
    send_event(OP_ACK, 21'h1FFFFF, 32'd5);
    send_event(OP_ACK, 21'd0, 32'hFFFF_FFF0);
    send_event(OP_ACK, 21'd0, 32'd10);
    send_event(OP_NONE, 21'h0AAAAA, 32'hFFFF_FFFF);
    drain();
    write_reg(REG_FINAL_SEQ, 32'd999998);
    write_reg(REG_TMO_OFFSET, 32'd65535);
    write_reg(REG_INIT_RTT, 32'd65535);
    send_event(OP_START, 21'h155555, 32'd100);
    for (int i = 0; i < 8; i++) send_event(OP_ACK, 21'(sb.acked + 1), 32'd100 + 7 * i);
    send_event(OP_TIMEOUT, 21'd0, 32'd200);
    send_event(OP_ACK, 21'(sb.acked + sb.flight), 32'hFFFF_0000);
    send_event(OP_ACK, 21'(sb.acked), 32'd300);
    for (int i = 0; i < 4; i++) send_event(OP_TIMEOUT, 21'd0, 32'd400);
    send_event(OP_ACK, 21'h1FFFFF, 32'd500);
    drain();

    // window up to its cap, with the final sequence near the top of the sequence space
    write_reg(REG_FINAL_SEQ, 32'd0);
    write_reg(REG_TMO_OFFSET, 32'd0);
    write_reg(REG_INIT_RTT, 32'd1);
    drain();
    write_reg(REG_FINAL_SEQ, 32'd999998);
    send_event(OP_START, 21'd0, next_now());
    for (int i = 0; i < 70; i++) send_event(OP_ACK, 21'(sb.acked + 1), next_now());
    random_phase(20);
    drain();

    write_reg(REG_FINAL_SEQ, 32'd150);
    write_reg(REG_TMO_OFFSET, 32'd50);
    write_reg(REG_INIT_RTT, 32'd3000);
    send_event(OP_START, 21'd0, next_now());
    random_phase(90);
    drain();

    write_reg(REG_FINAL_SEQ, $urandom_range(20, 3000));
    write_reg(REG_TMO_OFFSET, $urandom_range(0, 65535));
    write_reg(REG_INIT_RTT, $urandom_range(1, 65535));
    send_event(OP_START, 21'd0, next_now());
    random_phase(50);
    idling = 1'b0;
    random_phase(50);
    drain();

    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("covered %0d events, %0d results, %0d send grants", sb.items, sb.results,
             sb.grants);
    $display("window growth to cap, losses, collapse, stale and corrupt acks, done state");
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
